// ===== sv/prcs_pkg.sv =====
`default_nettype none

package prcs_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int DUTY_FRAC_BITS   = 16;
    localparam int DUTY_W           = DUTY_FRAC_BITS + 1;
    localparam int CLK_W            = 31;
    localparam int CODE_W           = 3;
    localparam int TCLK_W           = CLK_W + 1;
    localparam int FREQ_W           = 32;
    localparam int OUT_W            = 16;
    // wide enough for the 32-bit timer clock and for 2**COUNTER_BITS + 1
    localparam int DIV_W            = 33;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [CLK_W-1:0]  BUS_CLOCK_RST  = CLK_W'(42000000);
    localparam logic [CODE_W-1:0] PRESC_CODE_RST = CODE_W'(4);

    // register select is byte address bit 2
    localparam logic REG_BUS_CLOCK  = 1'b0;
    localparam logic REG_PRESC_CODE = 1'b1;

    typedef struct packed {
        logic [FREQ_W-1:0] pwm_freq_hz;
        logic [16:0]       duty_fraction;
    } prcs_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] prescaler;
        logic [OUT_W-1:0] reload;
        logic [OUT_W-1:0] compare;
    } prcs_rsp_t;

    typedef enum logic [1:0] {
        OP_PRESC,
        OP_QUOT,
        OP_ARR
    } prcs_op_t;

    typedef struct packed {
        logic     load;
        logic     need_mul;
        logic     need_fix;
        logic     start;
        prcs_op_t op;
        logic     save;
        logic     mul;
        logic     ccr;
        logic     fin;
    } prcs_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } prcs_sts_t;

endpackage

`default_nettype wire

// ===== sv/prcs_div.sv =====
`default_nettype none

module prcs_div
    import prcs_pkg::*;
#(
    parameter int W = DIV_W
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       ge;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = ~diff[W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/prcs_ctrl.sv =====
`default_nettype none

module prcs_ctrl
    import prcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire prcs_sts_t sts,
    output prcs_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEED,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL,
        S_CCR,
        S_DONE
    } state_t;

    state_t   state_reg, state_next;
    prcs_op_t op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load     = req_valid;
                cmd.need_mul = req_valid;
                if (req_valid)
                begin
                    state_next = S_NEED;
                    op_next    = OP_PRESC;
                end
            end
            S_NEED:
            begin
                cmd.need_fix = 1'b1;
                state_next   = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.save   = 1'b1;
                    state_next = S_DIV_GO;
                    case (op_reg)
                        OP_PRESC: op_next = OP_QUOT;
                        OP_QUOT:  op_next = OP_ARR;
                        OP_ARR:   state_next = S_MUL;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CCR;
            end
            S_CCR:
            begin
                cmd.ccr    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait until the output register is empty or being drained
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PRESC;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/prcs_dp.sv =====
`default_nettype none

module prcs_dp
    import prcs_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prcs_cmd_t         cmd,
    output prcs_sts_t              sts,
    input  wire prcs_req_t         req,
    input  wire logic [CLK_W-1:0]  bus_clock_hz,
    input  wire logic [CODE_W-1:0] bus_prescale_code,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output prcs_rsp_t              rsp
);

    localparam int CB     = COUNTER_BITS;
    localparam int PROD_W = CB + 1 + DUTY_W;
    localparam int NPROD_W = 2 * TCLK_W;
    localparam logic [DIV_W-1:0]  CNT_MAX  = DIV_W'((64'd1 << CB) - 64'd1);
    localparam logic [DIV_W-1:0]  NEED_DIV = CNT_MAX + DIV_W'(2);
    // floor(2**32 / (2**CB + 1)); the estimate it gives is at most one low
    localparam logic [TCLK_W-1:0] NEED_RECIP =
        TCLK_W'((64'd1 << TCLK_W) / ((64'd1 << CB) + 64'd1));
    localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << DUTY_FRAC_BITS;
    localparam logic [PROD_W:0]   HALF     = (PROD_W + 1)'(1) << (DUTY_FRAC_BITS - 1);

    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [NPROD_W-1:0] nprod_reg, nprod_next;
    logic [TCLK_W-1:0]  need_reg, need_next;
    logic [TCLK_W-1:0]  quot_reg, quot_next;
    logic [CB-1:0]      presc_reg, presc_next;
    logic [CB-1:0]      arr_reg, arr_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CB-1:0]      ccr_reg, ccr_next;
    prcs_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [TCLK_W-1:0] tclk;
    logic [TCLK_W-1:0] need_est;
    logic [DIV_W-1:0]  need_back;
    logic [DIV_W-1:0]  need_rem;
    logic [DIV_W-1:0]  div_a;
    logic [DIV_W-1:0]  div_b;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic [DIV_W-1:0]  div_r;
    logic [DIV_W-1:0]  p1;
    logic [DIV_W-1:0]  presc_full;
    logic [DIV_W-1:0]  arr_full;
    logic [DUTY_W-1:0] duty_in;
    logic [CB:0]       arr_p1;
    logic [PROD_W:0]   round_sum;
    logic [PROD_W:0]   ccr_full;

    // prescale codes 4 and above double the timer clock
    assign tclk = bus_prescale_code[CODE_W-1] ? {bus_clock_hz, 1'b0} : {1'b0, bus_clock_hz};

    always_comb
    begin
        case (cmd.op)
            OP_PRESC:
            begin
                div_a = DIV_W'(need_reg);
                div_b = DIV_W'(freq_reg);
            end
            OP_QUOT:
            begin
                div_a = DIV_W'(tclk);
                div_b = DIV_W'(freq_reg);
            end
            OP_ARR:
            begin
                // T / ((P+1)*F) taken as (T / F) / (P+1)
                div_a = DIV_W'(quot_reg);
                div_b = DIV_W'(presc_reg) + DIV_W'(1);
            end
            default:
            begin
                div_a = '0;
                div_b = DIV_W'(1);
            end
        endcase
    end

    prcs_div #(
        .W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        duty_in    = DUTY_W'(req.duty_fraction);
        // reload bound T / (2**CB + 1): reciprocal estimate, then one correction
        need_est   = nprod_reg[NPROD_W-1:TCLK_W];
        need_back  = (DIV_W'(need_est) << CB) + DIV_W'(need_est);
        need_rem   = DIV_W'(tclk) - need_back;
        // smallest P + 1 is the rounded-up quotient, never below one
        p1         = div_q + DIV_W'(div_r != '0);
        presc_full = p1 - DIV_W'(1);
        arr_full   = (div_q != '0) ? div_q - DIV_W'(1) : div_q;
        arr_p1     = (CB + 1)'(arr_reg) + (CB + 1)'(1);
        round_sum  = (PROD_W + 1)'(prod_reg) + HALF;
        ccr_full   = round_sum >> DUTY_FRAC_BITS;

        freq_next      = freq_reg;
        duty_next      = duty_reg;
        nprod_next     = nprod_reg;
        need_next      = need_reg;
        quot_next      = quot_reg;
        presc_next     = presc_reg;
        arr_next       = arr_reg;
        prod_next      = prod_reg;
        ccr_next       = ccr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            freq_next = (req.pwm_freq_hz == '0) ? FREQ_W'(1) : req.pwm_freq_hz;
            duty_next = (duty_in > DUTY_ONE) ? DUTY_ONE : duty_in;
        end

        if (cmd.need_mul)
        begin
            nprod_next = NPROD_W'(tclk) * NPROD_W'(NEED_RECIP);
        end

        if (cmd.need_fix)
        begin
            need_next = need_est + TCLK_W'(need_rem >= NEED_DIV) + TCLK_W'(1);
        end

        if (cmd.save)
        begin
            case (cmd.op)
                OP_PRESC: presc_next = (presc_full > CNT_MAX) ? CNT_MAX[CB-1:0]
                                                               : presc_full[CB-1:0];
                OP_QUOT:  quot_next = div_q[TCLK_W-1:0];
                OP_ARR:   arr_next = (arr_full > CNT_MAX) ? CNT_MAX[CB-1:0]
                                                           : arr_full[CB-1:0];
                default:  need_next = need_reg;
            endcase
        end

        if (cmd.mul)
        begin
            prod_next = PROD_W'(arr_p1) * PROD_W'(duty_reg);
        end

        if (cmd.ccr)
        begin
            ccr_next = (ccr_full > (PROD_W + 1)'(arr_reg)) ? arr_reg : ccr_full[CB-1:0];
        end

        if (cmd.fin)
        begin
            rsp_next.prescaler = OUT_W'(presc_reg);
            rsp_next.reload    = OUT_W'(arr_reg);
            rsp_next.compare   = OUT_W'(ccr_reg);
            rsp_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg  <= freq_next;
        duty_reg  <= duty_next;
        nprod_reg <= nprod_next;
        need_reg  <= need_next;
        quot_reg  <= quot_next;
        presc_reg <= presc_next;
        arr_reg   <= arr_next;
        prod_reg  <= prod_next;
        ccr_reg   <= ccr_next;
        rsp_reg   <= rsp_next;
    end

    assign sts.div_done = div_done;
    assign sts.out_free = ~rsp_valid_reg | ~rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/pwm_prescaler_reload_compare_solver.sv =====
// PWM timer settings solver: each request beat carries a PWM frequency in hertz
// (0 taken as 1) and a Q1.16 duty (65536 = fully on, larger values clamp) and
// yields one result beat with the prescaler, auto-reload and compare values for
// a COUNTER_BITS-wide timer clocked from the bus clock (doubled for prescale
// codes 4..7). Each request holds off the next until its result is loaded: one
// reciprocal multiply and one correction step for the reload bound, then three
// passes of one shared 33-bit restoring divider (prescaler, timer clock over
// frequency, reload), then one multiply and one rounding step for the compare
// value, then the load of the output register, which waits only while an
// earlier result is still stalled there. Results wait in that output register,
// so the next request is taken while the previous result is still stalled.
// Registers sit at byte address 0 (bus_clock_hz) and 4 (bus_prescale_code) and
// should be written only while no request is in flight.
`default_nettype none

module pwm_prescaler_reload_compare_solver
    import prcs_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire prcs_req_t         req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output prcs_rsp_t              rsp
);

    logic [CLK_W-1:0]  bus_clock_reg, bus_clock_next;
    logic [CODE_W-1:0] presc_code_reg, presc_code_next;
    logic              wr_en;
    prcs_cmd_t         cmd;
    prcs_sts_t         sts;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        bus_clock_next  = bus_clock_reg;
        presc_code_next = presc_code_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_BUS_CLOCK:  bus_clock_next = pwdata[CLK_W-1:0];
                REG_PRESC_CODE: presc_code_next = pwdata[CODE_W-1:0];
                default:        bus_clock_next = bus_clock_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BUS_CLOCK:  prdata = DATA_W'(bus_clock_reg);
            REG_PRESC_CODE: prdata = DATA_W'(presc_code_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_clock_reg  <= BUS_CLOCK_RST;
            presc_code_reg <= PRESC_CODE_RST;
        end
        else
        begin
            bus_clock_reg  <= bus_clock_next;
            presc_code_reg <= presc_code_next;
        end
    end

    prcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    prcs_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req               (req),
        .bus_clock_hz      (bus_clock_reg),
        .bus_prescale_code (presc_code_reg),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .rsp               (rsp)
    );

endmodule

`default_nettype wire

// ===== dv/tb_pwm_prescaler_reload_compare_solver.sv =====
`default_nettype none

module tb_pwm_prescaler_reload_compare_solver
    import prcs_pkg::*;
();

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          PHASE_ITEMS  = 105;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          MAX_WAIT     = 10;
    localparam int unsigned DUTY_ONE     = 1 << DUTY_FRAC_BITS;
    localparam int unsigned DUTY_MAX     = (1 << DUTY_W) - 1;
    // prescale codes from here on double the timer clock
    localparam int unsigned DOUBLING_CODE = 4;

    localparam logic [FREQ_W-1:0] EDGE_FREQS [16] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd640, 32'd641, 32'd1282, 32'd1000,
        32'd20000, 32'd65535, 32'd65536, 32'd42000000, 32'd84000000,
        32'd84000001, 32'h8000_0000, 32'hFFFF_FFFF
    };
    localparam logic [DUTY_W-1:0] EDGE_DUTIES [16] = '{
        17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65535, 17'd32767,
        17'd65537, 17'd0, 17'd65536, 17'd32769, 17'd100000, 17'd0, 17'd65536,
        17'd131071, 17'd32768
    };

    class timer_settings_board;
        logic [CLK_W-1:0]  bus_clk;
        logic [CODE_W-1:0] presc_code;
        prcs_rsp_t         pending_settings[$];
        int                errors;

        function new();
            bus_clk    = BUS_CLOCK_RST;
            presc_code = PRESC_CODE_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic sel, logic [DATA_W-1:0] value);
            if (sel == REG_BUS_CLOCK)
                bus_clk = value[CLK_W-1:0];
            else
                presc_code = value[CODE_W-1:0];
        endfunction

        function prcs_rsp_t solve_timer_settings(prcs_req_t r);
            longint unsigned top, one, freq, duty, tclk, need, presc, arr, ccr;
            prcs_rsp_t       s;
            top  = (64'd1 << COUNTER_BITS_DEF) - 1;
            one  = 64'd1 << DUTY_FRAC_BITS;
            freq = r.pwm_freq_hz;
            duty = r.duty_fraction;
            if (freq == 0)
                freq = 1;
            if (duty > one)
                duty = one;
            tclk = bus_clk;
            if (presc_code >= DOUBLING_CODE)
                tclk = tclk << 1;
            // smallest divider product that keeps the reload inside the counter
            need  = tclk / (top + 2) + 1;
            presc = (need + freq - 1) / freq - 1;
            if (presc > top)
                presc = top;
            arr = tclk / ((presc + 1) * freq);
            if (arr > 0)
                arr = arr - 1;
            if (arr > top)
                arr = top;
            ccr = ((arr + 1) * duty + (one >> 1)) >> DUTY_FRAC_BITS;
            if (ccr > arr)
                ccr = arr;
            s.prescaler = presc[OUT_W-1:0];
            s.reload    = arr[OUT_W-1:0];
            s.compare   = ccr[OUT_W-1:0];
            return s;
        endfunction

        function void note_request(prcs_req_t r);
            pending_settings.push_back(solve_timer_settings(r));
        endfunction

        function void check_result(prcs_rsp_t got);
            prcs_rsp_t want;
            if (pending_settings.size() == 0)
            begin
                $display("%0t: unexpected result prescaler %0d reload %0d compare %0d",
                         $time, got.prescaler, got.reload, got.compare);
                errors++;
                return;
            end
            want = pending_settings.pop_front();
            if (got.prescaler !== want.prescaler)
            begin
                $display("%0t: prescaler expected %0d actual %0d",
                         $time, want.prescaler, got.prescaler);
                errors++;
            end
            if (got.reload !== want.reload)
            begin
                $display("%0t: reload expected %0d actual %0d",
                         $time, want.reload, got.reload);
                errors++;
            end
            if (got.compare !== want.compare)
            begin
                $display("%0t: compare expected %0d actual %0d",
                         $time, want.compare, got.compare);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    prcs_req_t         req;
    logic              rsp_valid;
    logic              rsp_stall;
    prcs_rsp_t         rsp;

    timer_settings_board sb = new();
    int                  cycles = 0;
    bit                  req_quiet = 1'b0;
    bit                  rsp_quiet = 1'b0;

    pwm_prescaler_reload_compare_solver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(sel, value);
    endtask

    // valid is left high on return; the next beat or end_requests settles it
    task automatic send_request(input prcs_req_t r);
        int unsigned gap;
        if ($urandom_range(0, 29) == 0)
            req_quiet = !req_quiet;
        gap = req_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
    endtask

    task automatic end_requests();
        req_valid <= 1'b0;
        while (sb.pending_settings.size() != 0)
            @(posedge clk);
    endtask

    function automatic prcs_req_t random_request();
        prcs_req_t r;
        case ($urandom_range(0, 9))
            0:       r.pwm_freq_hz = $urandom_range(0, 3);
            7:       r.pwm_freq_hz = $urandom;
            8:       r.pwm_freq_hz = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: r.pwm_freq_hz = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 7))
            0:       r.duty_fraction = '0;
            1:       r.duty_fraction = DUTY_W'(DUTY_ONE);
            2:       r.duty_fraction = DUTY_W'($urandom_range(DUTY_ONE + 1, DUTY_MAX));
            3:       r.duty_fraction = DUTY_W'($urandom_range(DUTY_ONE / 2 - 2,
                                                              DUTY_ONE / 2 + 2));
            default: r.duty_fraction = DUTY_W'($urandom_range(0, DUTY_ONE));
        endcase
        return r;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_request(random_request());
        end_requests();
    endtask

    initial
    begin
        prcs_rsp_t got;
        rsp_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            int unsigned hold;
            if ($urandom_range(0, 29) == 0)
                rsp_quiet = !rsp_quiet;
            hold = rsp_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            got = rsp;
            sb.check_result(got);
        end
    end

    initial
    begin
        prcs_req_t r;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: edge frequencies and duties
        for (int i = 0; i < 16; i++)
        begin
            r.pwm_freq_hz   = EDGE_FREQS[i];
            r.duty_fraction = EDGE_DUTIES[i];
            send_request(r);
        end
        random_phase(PHASE_ITEMS);

        // fastest timer clock
        write_reg(REG_BUS_CLOCK, 32'h7FFF_FFFF);
        write_reg(REG_PRESC_CODE, 32'd7);
        for (int i = 0; i < 4; i++)
        begin
            r.pwm_freq_hz   = (i < 2) ? FREQ_W'(i) : 32'hFFFF_FFFF;
            r.duty_fraction = i[0] ? DUTY_W'(DUTY_ONE) : DUTY_W'(DUTY_ONE / 2 - 1);
            send_request(r);
        end
        random_phase(PHASE_ITEMS);

        write_reg(REG_BUS_CLOCK, 32'd1);
        write_reg(REG_PRESC_CODE, 32'd0);
        random_phase(PHASE_ITEMS);

        // stopped bus clock
        write_reg(REG_BUS_CLOCK, 32'd0);
        write_reg(REG_PRESC_CODE, 32'd4);
        random_phase(PHASE_ITEMS);

        write_reg(REG_BUS_CLOCK, $urandom);
        write_reg(REG_PRESC_CODE, $urandom);
        random_phase(PHASE_ITEMS);

        write_reg(REG_BUS_CLOCK, 32'd16000000);
        write_reg(REG_PRESC_CODE, 32'd3);
        random_phase(PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_settings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/prcs_pkg.sv
sv/prcs_div.sv
sv/prcs_ctrl.sv
sv/prcs_dp.sv
sv/pwm_prescaler_reload_compare_solver.sv
dv/tb_pwm_prescaler_reload_compare_solver.sv
